@@ rtl/vfc_pkg.sv @@
// Shared types, codes and constant tables of the voxel face-culling mesher.
`timescale 1ns / 1ps

package vfc_pkg;

    // Fixed field widths
    localparam int COORD_W  = 5;
    localparam int TYPE_W   = 8;
    localparam int FACE_W   = 3;
    localparam int CORNER_W = 18;
    localparam int NUM_FACES = 6;
    localparam int NUM_CORNERS = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WATER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_NEAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FAR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_DOWN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_UP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEFT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RIGHT = 3'd6;

    // Face directions, same encoding as the side field
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd5;
    localparam logic [FACE_W-1:0] FACE_COUNT = 3'd6;

    // Axis selector (face / 2)
    localparam logic [1:0] AXIS_Z = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_X = 2'd2;

    typedef enum logic [1:0] {
        OP_WR_VOXEL   = 2'd0,
        OP_WR_PLANE   = 2'd1,
        OP_WR_PRESENT = 2'd2,
        OP_QUERY      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CENTER,
        S_FACES,
        S_EMIT
    } t_state;

    // Corner order of the two triangles of each face; bit 2 = +x, bit 1 = +y, bit 0 = +z
    localparam logic [2:0] CORNER_TAB [NUM_FACES][NUM_CORNERS] = '{
        '{3'd0, 3'd2, 3'd4, 3'd4, 3'd2, 3'd6},
        '{3'd5, 3'd3, 3'd1, 3'd7, 3'd3, 3'd5},
        '{3'd0, 3'd4, 3'd1, 3'd4, 3'd5, 3'd1},
        '{3'd3, 3'd6, 3'd2, 3'd3, 3'd7, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd2},
        '{3'd6, 3'd5, 3'd4, 3'd6, 3'd7, 3'd5}
    };

    // Controller to datapath
    typedef struct packed {
        logic latch_in;     // capture the accepted input beat
        logic wr_voxel;     // store block type into the chunk
        logic wr_plane;     // store block type into a boundary plane
        logic wr_present;   // update a neighbour presence flag
        logic rd_center;    // read the queried voxel, form base index
        logic take_center;  // capture the queried voxel, start neighbour reads
        logic eval_face;    // judge one face, read the next neighbour
        logic load_out;     // move the next visible face into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic args_ok;
        logic is_air;
        logic last_face;
        logic mask_any;
        logic mask_single;
    } t_status;

endpackage

@@ rtl/vfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/vfc_ctrl.sv @@
// Sequencing state machine of the voxel face-culling mesher.
`timescale 1ns / 1ps

module vfc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  vfc_pkg::t_status i_status,
    output vfc_pkg::t_cmd    o_cmd
);

    vfc_pkg::t_state r_state;
    vfc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            accept;
    logic            out_free;

    assign o_in_ready  = (r_state == vfc_pkg::S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vfc_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = vfc_pkg::S_EXEC;
                end
            end
            vfc_pkg::S_EXEC: begin
                if (i_status.op == vfc_pkg::OP_QUERY && i_status.args_ok) begin
                    n_state = vfc_pkg::S_CENTER;
                end else begin
                    n_state = vfc_pkg::S_IDLE;
                end
            end
            vfc_pkg::S_CENTER: begin
                n_state = i_status.is_air ? vfc_pkg::S_IDLE : vfc_pkg::S_FACES;
            end
            vfc_pkg::S_FACES: begin
                if (i_status.last_face) begin
                    n_state = vfc_pkg::S_EMIT;
                end
            end
            vfc_pkg::S_EMIT: begin
                if (!i_status.mask_any) begin
                    n_state = vfc_pkg::S_IDLE;
                end else if (out_free && i_status.mask_single) begin
                    n_state = vfc_pkg::S_IDLE;
                end
            end
            default: n_state = vfc_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            vfc_pkg::S_IDLE: begin
                o_cmd.latch_in = accept;
            end
            vfc_pkg::S_EXEC: begin
                unique case (i_status.op)
                    vfc_pkg::OP_WR_VOXEL:   o_cmd.wr_voxel   = i_status.args_ok;
                    vfc_pkg::OP_WR_PLANE:   o_cmd.wr_plane   = i_status.args_ok;
                    vfc_pkg::OP_WR_PRESENT: o_cmd.wr_present = i_status.args_ok;
                    vfc_pkg::OP_QUERY:      o_cmd.rd_center  = i_status.args_ok;
                    default:                o_cmd = '0;
                endcase
            end
            vfc_pkg::S_CENTER: begin
                o_cmd.take_center = 1'b1;
            end
            vfc_pkg::S_FACES: begin
                o_cmd.eval_face = 1'b1;
            end
            vfc_pkg::S_EMIT: begin
                o_cmd.load_out = i_status.mask_any && out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // Output beat valid: set on load, drop when taken
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vfc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    // A new face never overwrites a beat the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while stalled");

    // Face scan ends in the emit phase
    a_scan_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vfc_pkg::S_FACES && i_status.last_face) |=> r_state == vfc_pkg::S_EMIT)
        else $error("face scan did not hand over to emit");

    // Emit is left only with no face pending or with the final face loaded
    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vfc_pkg::S_EMIT && n_state == vfc_pkg::S_IDLE)
            |-> (!i_status.mask_any || (o_cmd.load_out && i_status.mask_single)))
        else $error("query left emit with visible faces pending");

    // Loading a face raises output valid in the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded face not presented");
`endif

endmodule

@@ rtl/vfc_datapath.sv @@
// Storage, address generation, visibility test and corner index arithmetic.
`timescale 1ns / 1ps

module vfc_datapath #(
    parameter int CUBE_DIM = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  vfc_pkg::t_cmd                        i_cmd,
    output vfc_pkg::t_status                     o_status,
    // Configuration
    input  logic                                 i_cfg_we,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [vfc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input payload
    input  logic [1:0]                           i_operation,
    input  logic [vfc_pkg::COORD_W-1:0]          i_pos_x,
    input  logic [vfc_pkg::COORD_W-1:0]          i_pos_y,
    input  logic [vfc_pkg::COORD_W-1:0]          i_pos_z,
    input  logic signed [vfc_pkg::TYPE_W-1:0]    i_block_type,
    input  logic [vfc_pkg::FACE_W-1:0]           i_side,
    input  logic                                 i_present,
    // Output payload
    output logic [vfc_pkg::FACE_W-1:0]           o_face,
    output logic                                 o_translucent,
    output logic [vfc_pkg::CORNER_W-1:0]         o_corner [vfc_pkg::NUM_CORNERS],
    output logic                                 o_last
);

    localparam int SS          = CUBE_DIM * CUBE_DIM;
    localparam int S1          = CUBE_DIM + 1;
    localparam int VOX_DEPTH   = SS * CUBE_DIM;
    localparam int PLANE_DEPTH = vfc_pkg::NUM_FACES * SS;
    localparam int VA_W        = $clog2(VOX_DEPTH);
    localparam int PA_W        = $clog2(PLANE_DEPTH);
    localparam int CW          = vfc_pkg::CORNER_W;
    localparam int TW          = vfc_pkg::TYPE_W;
    localparam int NF          = vfc_pkg::NUM_FACES;

    localparam logic [CW-1:0]   VERTS_C = CW'(S1 * S1 * S1);
    localparam logic [CW-1:0]   OFF_X   = CW'(S1 * S1);
    localparam logic [CW-1:0]   OFF_Y   = CW'(S1);
    localparam logic [VA_W-1:0] STEP_Z  = VA_W'(SS);
    localparam logic [VA_W-1:0] STEP_Y  = VA_W'(CUBE_DIM);
    localparam logic [VA_W-1:0] STEP_X  = VA_W'(1);
    localparam logic [31:0]     SIZE_U  = 32'(CUBE_DIM);
    localparam logic [31:0]     EDGE_U  = 32'(CUBE_DIM - 1);

    // Latched input beat
    vfc_pkg::t_op                 r_op;
    logic [vfc_pkg::COORD_W-1:0]  r_x;
    logic [vfc_pkg::COORD_W-1:0]  r_y;
    logic [vfc_pkg::COORD_W-1:0]  r_z;
    logic signed [TW-1:0]         r_bt;
    logic [vfc_pkg::FACE_W-1:0]   r_side;
    logic                         r_pres;

    // Configuration and presence
    logic signed [TW-1:0]         r_water;
    logic [vfc_pkg::FACE_W-1:0]   r_codes [NF];
    logic [NF-1:0]                r_present;

    // Query state
    logic [VA_W-1:0]              r_caddr;
    logic [CW-1:0]                r_base;
    logic signed [TW-1:0]         r_blk;
    logic                         r_opaque;
    logic [vfc_pkg::FACE_W-1:0]   r_face;
    logic [NF-1:0]                r_mask;
    logic [NF-1:0]                n_mask;

    // Output register
    logic [vfc_pkg::FACE_W-1:0]   r_o_face;
    logic                         r_o_transl;
    logic                         r_o_last;
    logic [CW-1:0]                r_o_corner [vfc_pkg::NUM_CORNERS];
    logic [CW-1:0]                n_corner   [vfc_pkg::NUM_CORNERS];

    // Memory ports
    logic [VA_W-1:0]              vox_raddr;
    logic                         vox_re;
    logic [TW-1:0]                vox_rdata;
    logic [PA_W-1:0]              pl_raddr;
    logic [PA_W-1:0]              pl_waddr;
    logic                         pl_re;
    logic [TW-1:0]                pl_rdata;

    // Combinational helpers
    logic                         x_ok;
    logic                         y_ok;
    logic                         z_ok;
    logic                         side_ok;
    logic                         plane_ok;
    logic                         args_ok;
    logic [VA_W-1:0]              vaddr_c;
    logic [vfc_pkg::FACE_W-1:0]   rd_face;
    logic                         issue;
    logic                         rd_bnd;
    logic                         cur_bnd;
    logic signed [TW-1:0]         nbr_type;
    logic                         vis;
    logic [vfc_pkg::FACE_W-1:0]   sel;
    logic [CW-1:0]                face_off;

    // True when the face of (x,y,z) lies on the chunk boundary
    function automatic logic on_boundary(
        input logic [vfc_pkg::FACE_W-1:0] face,
        input logic [vfc_pkg::COORD_W-1:0] x,
        input logic [vfc_pkg::COORD_W-1:0] y,
        input logic [vfc_pkg::COORD_W-1:0] z
    );
        logic [vfc_pkg::COORD_W-1:0] c;
        unique case (face[2:1])
            vfc_pkg::AXIS_Z: c = z;
            vfc_pkg::AXIS_Y: c = y;
            vfc_pkg::AXIS_X: c = x;
            default:         c = x;
        endcase
        if (face[0]) begin
            return 32'(c) == EDGE_U;
        end
        return c == '0;
    endfunction

    // Plane cell address: the two coordinates off the face's axis, in x, y, z order
    function automatic logic [PA_W-1:0] plane_addr(
        input logic [vfc_pkg::FACE_W-1:0] face,
        input logic [vfc_pkg::COORD_W-1:0] x,
        input logic [vfc_pkg::COORD_W-1:0] y,
        input logic [vfc_pkg::COORD_W-1:0] z
    );
        logic [vfc_pkg::COORD_W-1:0] a;
        logic [vfc_pkg::COORD_W-1:0] b;
        unique case (face[2:1])
            vfc_pkg::AXIS_Z: begin a = x; b = y; end
            vfc_pkg::AXIS_Y: begin a = x; b = z; end
            default:         begin a = y; b = z; end
        endcase
        return PA_W'(face) * PA_W'(SS) + PA_W'(a) * PA_W'(CUBE_DIM) + PA_W'(b);
    endfunction

    // Address of the interior neighbour across a face
    function automatic logic [VA_W-1:0] nbr_addr(
        input logic [vfc_pkg::FACE_W-1:0] face,
        input logic [VA_W-1:0]            ca
    );
        logic [VA_W-1:0] na;
        unique case (face)
            vfc_pkg::FACE_NEG_Z: na = ca - STEP_Z;
            vfc_pkg::FACE_POS_Z: na = ca + STEP_Z;
            vfc_pkg::FACE_NEG_Y: na = ca - STEP_Y;
            vfc_pkg::FACE_POS_Y: na = ca + STEP_Y;
            vfc_pkg::FACE_NEG_X: na = ca - STEP_X;
            vfc_pkg::FACE_POS_X: na = ca + STEP_X;
            default:             na = ca;
        endcase
        return na;
    endfunction

    // Range checks on the latched beat
    always_comb begin
        x_ok     = 32'(r_x) < SIZE_U;
        y_ok     = 32'(r_y) < SIZE_U;
        z_ok     = 32'(r_z) < SIZE_U;
        side_ok  = r_side < vfc_pkg::FACE_COUNT;
        plane_ok = side_ok
                && (r_side[2:1] == vfc_pkg::AXIS_X || x_ok)
                && (r_side[2:1] == vfc_pkg::AXIS_Y || y_ok)
                && (r_side[2:1] == vfc_pkg::AXIS_Z || z_ok);
        unique case (r_op)
            vfc_pkg::OP_WR_PLANE:   args_ok = plane_ok;
            vfc_pkg::OP_WR_PRESENT: args_ok = side_ok;
            default:                args_ok = x_ok && y_ok && z_ok;
        endcase
    end

    // Address generation for both memories
    assign vaddr_c  = VA_W'(r_z) * STEP_Z + VA_W'(r_y) * STEP_Y + VA_W'(r_x);
    assign rd_face  = i_cmd.take_center ? vfc_pkg::FACE_NEG_Z : r_face + 3'd1;
    assign issue    = i_cmd.take_center
                   || (i_cmd.eval_face && r_face != vfc_pkg::FACE_POS_X);
    assign rd_bnd   = on_boundary(rd_face, r_x, r_y, r_z);
    assign vox_re   = i_cmd.rd_center || (issue && !rd_bnd);
    assign vox_raddr = i_cmd.rd_center ? vaddr_c : nbr_addr(rd_face, r_caddr);
    assign pl_re    = issue && rd_bnd;
    assign pl_raddr = plane_addr(rd_face, r_x, r_y, r_z);
    assign pl_waddr = plane_addr(r_side, r_x, r_y, r_z);

    vfc_ram #(
        .WIDTH (TW),
        .DEPTH (VOX_DEPTH)
    ) u_voxel_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_voxel),
        .i_waddr (vaddr_c),
        .i_wdata (r_bt),
        .i_re    (vox_re),
        .i_raddr (vox_raddr),
        .o_rdata (vox_rdata)
    );

    vfc_ram #(
        .WIDTH (TW),
        .DEPTH (PLANE_DEPTH)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_plane),
        .i_waddr (pl_waddr),
        .i_wdata (r_bt),
        .i_re    (pl_re),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    // Visibility of the face whose neighbour data is arriving now
    always_comb begin
        cur_bnd  = on_boundary(r_face, r_x, r_y, r_z);
        nbr_type = cur_bnd ? $signed(pl_rdata) : $signed(vox_rdata);
        if (cur_bnd && !r_present[r_face]) begin
            vis = 1'b1;
        end else if (r_opaque) begin
            vis = nbr_type <= r_water;
        end else begin
            vis = nbr_type < r_blk;
        end
    end

    // Pick the lowest pending face
    always_comb begin
        sel = vfc_pkg::FACE_NEG_Z;
        for (int i = NF - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = vfc_pkg::FACE_W'(i);
            end
        end
    end

    // Corner indices of the selected face
    always_comb begin
        logic [2:0] m;
        face_off = CW'(r_codes[sel]) * VERTS_C;
        for (int k = 0; k < vfc_pkg::NUM_CORNERS; k++) begin
            m = vfc_pkg::CORNER_TAB[sel][k];
            n_corner[k] = face_off + r_base
                        + (m[2] ? OFF_X : '0)
                        + (m[1] ? OFF_Y : '0)
                        + CW'(m[0]);
        end
    end

    // Pending face mask
    always_comb begin
        n_mask = r_mask;
        if (i_cmd.take_center) begin
            n_mask = '0;
        end else if (i_cmd.eval_face) begin
            n_mask[r_face] = vis;
        end else if (i_cmd.load_out) begin
            n_mask[sel] = 1'b0;
        end
    end

    // Control state: config, presence, face counter, mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_water   <= 8'sd1;
            for (int i = 0; i < NF; i++) begin
                r_codes[i] <= vfc_pkg::FACE_W'(i);
            end
            r_present <= '0;
            r_face    <= vfc_pkg::FACE_NEG_Z;
            r_mask    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    vfc_pkg::CFG_WATER:      r_water <= $signed(i_cfg_data);
                    vfc_pkg::CFG_CODE_NEAR:  r_codes[0] <= i_cfg_data[2:0];
                    vfc_pkg::CFG_CODE_FAR:   r_codes[1] <= i_cfg_data[2:0];
                    vfc_pkg::CFG_CODE_DOWN:  r_codes[2] <= i_cfg_data[2:0];
                    vfc_pkg::CFG_CODE_UP:    r_codes[3] <= i_cfg_data[2:0];
                    vfc_pkg::CFG_CODE_LEFT:  r_codes[4] <= i_cfg_data[2:0];
                    vfc_pkg::CFG_CODE_RIGHT: r_codes[5] <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_cmd.wr_present) begin
                r_present[r_side] <= r_pres;
            end
            if (i_cmd.take_center) begin
                r_face <= vfc_pkg::FACE_NEG_Z;
            end else if (i_cmd.eval_face && r_face != vfc_pkg::FACE_POS_X) begin
                r_face <= r_face + 3'd1;
            end
            r_mask <= n_mask;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= vfc_pkg::t_op'(i_operation);
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_z    <= i_pos_z;
            r_bt   <= i_block_type;
            r_side <= i_side;
            r_pres <= i_present;
        end
        if (i_cmd.rd_center) begin
            r_caddr <= vaddr_c;
            r_base  <= CW'(r_x) * OFF_X + CW'(r_y) * OFF_Y + CW'(r_z);
        end
        if (i_cmd.take_center) begin
            r_blk    <= $signed(vox_rdata);
            r_opaque <= $signed(vox_rdata) > r_water;
        end
        if (i_cmd.load_out) begin
            r_o_face   <= sel;
            r_o_transl <= !r_opaque;
            r_o_last   <= o_status.mask_single;
            r_o_corner <= n_corner;
        end
    end

    // Status to the controller
    always_comb begin
        o_status.op          = r_op;
        o_status.args_ok     = args_ok;
        o_status.is_air      = vox_rdata == '0;
        o_status.last_face   = r_face == vfc_pkg::FACE_POS_X;
        o_status.mask_any    = |r_mask;
        o_status.mask_single = (|r_mask) && ((r_mask & (r_mask - 6'd1)) == '0);
    end

    assign o_face        = r_o_face;
    assign o_translucent = r_o_transl;
    assign o_corner      = r_o_corner;
    assign o_last        = r_o_last;

endmodule

@@ rtl/voxel_face_culling_mesher_top.sv @@
// Top level of the voxel face-culling mesher: controller, datapath and ports.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one beat per operation: write a
//   voxel, write a neighbour plane cell, set a neighbour presence flag, or query.
//   Output channel (o_out_valid / i_out_ready) gives one beat per visible face of
//   a query, in -z, +z, -y, +y, -x, +x order; o_last marks the final one. Writes
//   and queries without a visible face give no beat.
//   Configuration (i_cfg_we / i_cfg_index / i_cfg_data) writes water type and face
//   codes; write it only while no query is in flight.
//   Sequence: a write or an out-of-range query passes through the execute state back
//   to idle, an air query through the execute and center states. Otherwise the
//   queried voxel is read, then its six neighbours one per cycle over the single
//   read port of the voxel or plane memory, then one face is loaded per cycle while
//   the output register is free.
//   Stall: a stalled output beat holds; further faces wait in the face mask. The
//   last face may sit in the output register while the next beat is accepted.
//   Reset (synchronous, active low) clears presence flags and all control state and
//   sets face codes to their face index and water type to 1; the voxel and plane
//   memories are not cleared and must be written before they are read.

module voxel_face_culling_mesher_top #(
    parameter int CUBE_DIM = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration
    input  logic                               i_cfg_we,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_operation,
    input  logic [vfc_pkg::COORD_W-1:0]        i_pos_x,
    input  logic [vfc_pkg::COORD_W-1:0]        i_pos_y,
    input  logic [vfc_pkg::COORD_W-1:0]        i_pos_z,
    input  logic signed [vfc_pkg::TYPE_W-1:0]  i_block_type,
    input  logic [vfc_pkg::FACE_W-1:0]         i_side,
    input  logic                               i_present,
    // Output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [vfc_pkg::FACE_W-1:0]         o_face,
    output logic                               o_translucent,
    output logic [vfc_pkg::CORNER_W-1:0]       o_corner_0,
    output logic [vfc_pkg::CORNER_W-1:0]       o_corner_1,
    output logic [vfc_pkg::CORNER_W-1:0]       o_corner_2,
    output logic [vfc_pkg::CORNER_W-1:0]       o_corner_3,
    output logic [vfc_pkg::CORNER_W-1:0]       o_corner_4,
    output logic [vfc_pkg::CORNER_W-1:0]       o_corner_5,
    output logic                               o_last
);

    vfc_pkg::t_cmd        cmd;
    vfc_pkg::t_status     status;
    logic [vfc_pkg::CORNER_W-1:0] corner [vfc_pkg::NUM_CORNERS];

    vfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    vfc_datapath #(
        .CUBE_DIM (CUBE_DIM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_block_type  (i_block_type),
        .i_side        (i_side),
        .i_present     (i_present),
        .o_face        (o_face),
        .o_translucent (o_translucent),
        .o_corner      (corner),
        .o_last        (o_last)
    );

    assign o_corner_0 = corner[0];
    assign o_corner_1 = corner[1];
    assign o_corner_2 = corner[2];
    assign o_corner_3 = corner[3];
    assign o_corner_4 = corner[4];
    assign o_corner_5 = corner[5];

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the voxel face-culling mesher, scored by a culling predictor.
`timescale 1ns / 1ps

module tb_top;
    import vfc_pkg::*;

    localparam int CS        = 32;
    localparam int S1        = CS + 1;
    localparam int VERTS     = S1 * S1 * S1;
    localparam int VOX_CELLS = CS * CS * CS;
    localparam int PLN_CELLS = 6 * CS * CS;
    localparam int SETTLE    = 24;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    // Corner order of the two triangles per face: bit 2 = +x, bit 1 = +y, bit 0 = +z
    localparam logic [2:0] QUAD_CORNERS [6][6] = '{
        '{3'd0, 3'd2, 3'd4, 3'd4, 3'd2, 3'd6},
        '{3'd5, 3'd3, 3'd1, 3'd7, 3'd3, 3'd5},
        '{3'd0, 3'd4, 3'd1, 3'd4, 3'd5, 3'd1},
        '{3'd3, 3'd6, 3'd2, 3'd3, 3'd7, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd2},
        '{3'd6, 3'd5, 3'd4, 3'd6, 3'd7, 3'd5}
    };

    typedef struct packed {
        t_op        op;
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
        logic [7:0] bt;
        logic [2:0] side;
        logic       present;
    } t_vox_beat;

    typedef struct packed {
        logic [2:0]       face;
        logic             translucent;
        logic [5:0][17:0] corner;
        logic             last;
    } t_face_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = '0;
    logic [4:0]  i_pos_x = '0;
    logic [4:0]  i_pos_y = '0;
    logic [4:0]  i_pos_z = '0;
    logic signed [7:0] i_block_type = '0;
    logic [2:0]  i_side = '0;
    logic        i_present = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_face;
    logic        o_translucent;
    logic [17:0] o_corner_0, o_corner_1, o_corner_2, o_corner_3, o_corner_4, o_corner_5;
    logic        o_last;

    voxel_face_culling_mesher_top #(.CUBE_DIM(CS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .i_block_type(i_block_type), .i_side(i_side),
        .i_present(i_present),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_face(o_face), .o_translucent(o_translucent),
        .o_corner_0(o_corner_0), .o_corner_1(o_corner_1), .o_corner_2(o_corner_2),
        .o_corner_3(o_corner_3), .o_corner_4(o_corner_4), .o_corner_5(o_corner_5),
        .o_last(o_last)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state and configuration
    byte        chunk_mem [VOX_CELLS];
    byte        plane_mem [PLN_CELLS];
    bit         nb_present [6];
    int         water_lvl;
    logic [2:0] face_code [6];

    // Stimulus bookkeeping: cells already written, so no query reads garbage
    bit         vox_done [VOX_CELLS];
    bit         plane_done [PLN_CELLS];
    int         seen_pos [$];
    int         gen_water;

    t_vox_beat  op_queue [$];
    t_face_beat face_queue [$];
    t_vox_beat  drv_beat;
    int         gap_left = 0;
    int         stall_left = 0;
    bit         quiet = 1'b0;
    bit         in_beat = 1'b0;
    int         errors = 0;
    int unsigned cycle_cnt = 0;

    function automatic int vox_addr(input int x, input int y, input int z);
        return (z * CS + y) * CS + x;
    endfunction

    // Plane cell uses the two coordinates off the side's axis
    function automatic int plane_addr(input int s, input int x, input int y, input int z);
        int a, b;
        if (s < 2) begin
            a = x;
            b = y;
        end else if (s < 4) begin
            a = x;
            b = z;
        end else begin
            a = y;
            b = z;
        end
        return (s * CS + a) * CS + b;
    endfunction

    // Apply one accepted beat to the chunk copy and queue the faces it shows
    task automatic cull_voxel_op(input t_vox_beat b);
        int x, y, z, blk, nt, f, k, axis, idx, n;
        int c [3];
        bit opaque, vis, plus;
        logic [2:0] m;
        t_face_beat hits [6];
        x = b.x;
        y = b.y;
        z = b.z;
        n = 0;
        case (b.op)
            OP_WR_PRESENT: if (b.side < 6) nb_present[b.side] = b.present;
            OP_WR_PLANE:   if (b.side < 6) plane_mem[plane_addr(b.side, x, y, z)] = byte'(b.bt);
            OP_WR_VOXEL:   chunk_mem[vox_addr(x, y, z)] = byte'(b.bt);
            default: begin
                blk = chunk_mem[vox_addr(x, y, z)];
                if (blk != 0) begin
                    opaque = blk > water_lvl;
                    for (f = 0; f < 6; f++) begin
                        axis = 2 - f / 2;
                        plus = (f % 2) != 0;
                        c[0] = x;
                        c[1] = y;
                        c[2] = z;
                        if (plus ? (c[axis] == CS - 1) : (c[axis] == 0)) begin
                            if (!nb_present[f]) begin
                                vis = 1'b1;
                            end else begin
                                nt = plane_mem[plane_addr(f, x, y, z)];
                                vis = opaque ? (nt <= water_lvl) : (nt < blk);
                            end
                        end else begin
                            c[axis] += plus ? 1 : -1;
                            nt = chunk_mem[vox_addr(c[0], c[1], c[2])];
                            vis = opaque ? (nt <= water_lvl) : (nt < blk);
                        end
                        if (vis) begin
                            hits[n].face = 3'(f);
                            hits[n].translucent = !opaque;
                            hits[n].last = 1'b0;
                            for (k = 0; k < 6; k++) begin
                                m = QUAD_CORNERS[f][k];
                                idx = int'(face_code[f]) * VERTS
                                    + (S1 * (x + m[2]) + y + m[1]) * S1 + z + m[0];
                                hits[n].corner[k] = idx[17:0];
                            end
                            n++;
                        end
                    end
                    if (n > 0) hits[n - 1].last = 1'b1;
                    for (k = 0; k < n; k++) face_queue.insert(face_queue.size(), hits[k]);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_face_beat want;
        logic [5:0][17:0] got_c;
        int k;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("voxel_face_culling_mesher_top verification failed");
            $finish;
        end else if (!i_rst_n) begin
            in_beat <= 1'b0;
        end else begin
            in_beat <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (face_queue.size() == 0) begin
                    $display("%0t: face beat with nothing expected: expected none, actual face %0d",
                             $time, o_face);
                    errors++;
                end else begin
                    want = face_queue.pop_front();
                    got_c = {o_corner_5, o_corner_4, o_corner_3,
                             o_corner_2, o_corner_1, o_corner_0};
                    check_field("face", want.face, o_face);
                    check_field("translucent", want.translucent, o_translucent);
                    for (k = 0; k < 6; k++)
                        check_field($sformatf("corner_%0d", k), want.corner[k], got_c[k]);
                    check_field("last", want.last, o_last);
                end
            end
            if (i_in_valid && o_in_ready)
                cull_voxel_op('{t_op'(i_operation), i_pos_x, i_pos_y, i_pos_z,
                                i_block_type, i_side, i_present});
        end
    end

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Input driver: present the next beat after the gap drawn for it
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (op_queue.size() > 0) begin
                drv_beat = op_queue.pop_front();
                i_operation  <= drv_beat.op;
                i_pos_x      <= drv_beat.x;
                i_pos_y      <= drv_beat.y;
                i_pos_z      <= drv_beat.z;
                i_block_type <= drv_beat.bt;
                i_side       <= drv_beat.side;
                i_present    <= drv_beat.present;
                i_in_valid   <= 1'b1;
                gap_left <= (quiet || $urandom_range(0, 1)) ? 0 : idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stalls, independent of valid
    always @(negedge i_clk) begin
        if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20) stall_left <= idle_len();
        end
    end

    task automatic push_beat(input t_op op, input int x, input int y, input int z,
                             input byte bt, input int side, input bit pres);
        t_vox_beat b;
        b = '{op, x[4:0], y[4:0], z[4:0], bt, side[2:0], pres};
        op_queue.insert(op_queue.size(), b);
        if (op == OP_WR_VOXEL) vox_done[vox_addr(x, y, z)] = 1'b1;
        if (op == OP_WR_PLANE && side < 6) plane_done[plane_addr(side, x, y, z)] = 1'b1;
    endtask

    // Plane write with a random coordinate along the side's axis
    task automatic push_plane(input int side, input int x, input int y, input int z, input byte t);
        int c [3];
        c[0] = x;
        c[1] = y;
        c[2] = z;
        if (side < 6) c[2 - side / 2] = $urandom_range(0, CS - 1);
        push_beat(OP_WR_PLANE, c[0], c[1], c[2], t, side, $urandom_range(0, 1));
    endtask

    // Write the cell across face f: a plane cell at the boundary, else a voxel
    task automatic write_adjacent(input int f, input int x, input int y, input int z,
                                  input byte t, input bit only_missing);
        int c [3];
        int axis;
        bit plus;
        axis = 2 - f / 2;
        plus = (f % 2) != 0;
        c[0] = x;
        c[1] = y;
        c[2] = z;
        if (plus ? (c[axis] == CS - 1) : (c[axis] == 0)) begin
            if (!only_missing || !plane_done[plane_addr(f, x, y, z)])
                push_plane(f, x, y, z, t);
        end else begin
            c[axis] += plus ? 1 : -1;
            if (!only_missing || !vox_done[vox_addr(c[0], c[1], c[2])])
                push_beat(OP_WR_VOXEL, c[0], c[1], c[2], t,
                          $urandom_range(0, 7), $urandom_range(0, 1));
        end
    endtask

    function automatic int pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, 2);
        if (r < 90) return $urandom_range(CS - 3, CS - 1);
        return $urandom_range(0, CS - 1);
    endfunction

    // Block types clustered around the water level and the extremes
    function automatic byte pick_type();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = -128;
            2: v = 127;
            3, 4: v = gen_water + int'($urandom_range(0, 4)) - 2;
            5, 6: v = int'($urandom_range(0, 6)) - 3;
            default: v = int'($urandom_range(0, 255)) - 128;
        endcase
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return byte'(v);
    endfunction

    task automatic push_query(input int x, input int y, input int z);
        push_beat(OP_QUERY, x, y, z, pick_type(), $urandom_range(0, 7), $urandom_range(0, 1));
        seen_pos.insert(seen_pos.size(), (x * CS + y) * CS + z);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WATER) begin
            water_lvl = int'($signed(data));
            gen_water = water_lvl;
        end else begin
            face_code[idx - CFG_CODE_NEAR] = data[2:0];
        end
    endtask

    // Hold until the input queue is empty and every face has come out
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (op_queue.size() != 0 || i_in_valid || face_queue.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic directed_beats();
        int f;
        push_beat(OP_WR_VOXEL, 0, 0, 0, 127, 0, 0);
        for (f = 0; f < 6; f++)
            write_adjacent(f, 0, 0, 0, (f % 2 == 0) ? -128 : 0, 1'b0);
        // all neighbours absent: every face shows
        push_query(0, 0, 0);
        push_beat(OP_WR_PRESENT, 0, 0, 0, 0, FACE_NEG_Z, 1);
        push_beat(OP_WR_PRESENT, 0, 0, 0, 0, FACE_NEG_Y, 1);
        push_beat(OP_WR_PRESENT, 0, 0, 0, 0, FACE_NEG_X, 1);
        push_beat(OP_WR_PRESENT, 0, 0, 0, 0, 6, 1);
        push_beat(OP_WR_PLANE, 31, 31, 31, 5, 7, 1);
        push_query(0, 0, 0);
        // opaque -z neighbour hides, neighbour at water level still shows
        write_adjacent(FACE_NEG_Z, 0, 0, 0, 127, 1'b0);
        write_adjacent(FACE_POS_X, 0, 0, 0, 1, 1'b0);
        push_query(0, 0, 0);
        push_beat(OP_WR_VOXEL, 0, 0, 0, -128, 7, 1);
        push_query(0, 0, 0);
        push_beat(OP_WR_VOXEL, 0, 0, 0, 1, 0, 0);
        push_query(0, 0, 0);
        push_beat(OP_WR_VOXEL, 0, 0, 0, 0, 0, 0);
        push_query(0, 0, 0);
        push_beat(OP_WR_PRESENT, 0, 0, 0, 0, FACE_NEG_Y, 0);
    endtask

    // Mostly well-formed query sequences, the rest stray writes and repeat queries
    task automatic random_beats(input int n);
        int i, x, y, z, p;
        for (i = 0; i < n; i++) begin
            x = pick_coord();
            y = pick_coord();
            z = pick_coord();
            if ($urandom_range(0, 99) < 60) begin
                if (!vox_done[vox_addr(x, y, z)])
                    push_beat(OP_WR_VOXEL, x, y, z, pick_type(), 0, 0);
                for (p = 0; p < 6; p++) write_adjacent(p, x, y, z, pick_type(), 1'b1);
                if ($urandom_range(0, 1))
                    push_beat(OP_WR_VOXEL, x, y, z, pick_type(),
                              $urandom_range(0, 7), $urandom_range(0, 1));
                if ($urandom_range(0, 9) < 4)
                    write_adjacent($urandom_range(0, 5), x, y, z, pick_type(), 1'b0);
                if ($urandom_range(0, 3) == 0)
                    push_beat(OP_WR_PRESENT, x, y, z, pick_type(),
                              $urandom_range(0, 5), $urandom_range(0, 1));
                push_query(x, y, z);
            end else begin
                case ($urandom_range(0, 3))
                    0: push_beat(OP_WR_VOXEL, x, y, z, pick_type(),
                                 $urandom_range(0, 7), $urandom_range(0, 1));
                    1: push_plane($urandom_range(0, 7), x, y, z, pick_type());
                    2: push_beat(OP_WR_PRESENT, x, y, z, pick_type(),
                                 $urandom_range(0, 7), $urandom_range(0, 1));
                    default: begin
                        if (seen_pos.size() > 0) begin
                            p = seen_pos[$urandom_range(0, seen_pos.size() - 1)];
                            push_query(p / (CS * CS), (p / CS) % CS, p % CS);
                        end else begin
                            push_beat(OP_WR_VOXEL, x, y, z, pick_type(), 0, 0);
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] wt, input logic [5:0][2:0] codes,
                             input bit no_idle, input int n);
        cfg_write(CFG_WATER, wt);
        cfg_write(CFG_CODE_NEAR, {5'd0, codes[0]});
        cfg_write(CFG_CODE_FAR, {5'd0, codes[1]});
        cfg_write(CFG_CODE_DOWN, {5'd0, codes[2]});
        cfg_write(CFG_CODE_UP, {5'd0, codes[3]});
        cfg_write(CFG_CODE_LEFT, {5'd0, codes[4]});
        cfg_write(CFG_CODE_RIGHT, {5'd0, codes[5]});
        quiet = no_idle;
        random_beats(n);
        wait_idle();
    endtask

    function automatic logic [5:0][2:0] random_codes();
        logic [5:0][2:0] c;
        int i;
        for (i = 0; i < 6; i++) c[i] = 3'($urandom_range(0, 7));
        return c;
    endfunction

    initial begin
        int i;
        // predictor copy of the reset state
        for (i = 0; i < 6; i++) begin
            nb_present[i] = 1'b0;
            face_code[i] = 3'(i);
        end
        water_lvl = 1;
        gen_water = 1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_beats();
        wait_idle();
        run_phase(8'd127, {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5}, 1'b0, 12);
        run_phase(8'h80, {3'd7, 3'd6, 3'd0, 3'd7, 3'd6, 3'd7}, 1'b0, 12);
        run_phase(8'($urandom_range(0, 255)), random_codes(), 1'b1, 12);
        run_phase(8'($urandom_range(0, 255)), random_codes(), 1'b0, 12);
        run_phase(8'd1, {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0}, 1'b0, 12);

        if (errors == 0 && face_queue.size() == 0)
            $display("voxel_face_culling_mesher_top verification clean");
        else
            $display("voxel_face_culling_mesher_top verification failed");
        $finish;
    end

endmodule
